@@ rtl/aes_ke_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aes_ke_pkg;

    // Schedule geometry
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KEY_WORDS  = 4;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned ROUND_W    = 4;
    localparam int unsigned ROUND_KEYS = 11;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(0);
    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(ROUND_KEYS - 1);

    typedef logic [WORD_W-1:0] word_t;

    // Word 0 sits in the most significant place, so the packed value reads as the key
    typedef logic [0:KEY_WORDS-1][WORD_W-1:0] key_words_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Round constant for the step that builds round key idx+1
    function automatic word_t rcon(input logic [ROUND_W-1:0] idx);
        word_t r;
        r = '0;
        case (idx)
            4'd0:    r = 32'h0100_0000;
            4'd1:    r = 32'h0200_0000;
            4'd2:    r = 32'h0400_0000;
            4'd3:    r = 32'h0800_0000;
            4'd4:    r = 32'h1000_0000;
            4'd5:    r = 32'h2000_0000;
            4'd6:    r = 32'h4000_0000;
            4'd7:    r = 32'h8000_0000;
            4'd8:    r = 32'h1b00_0000;
            4'd9:    r = 32'h3600_0000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/aes128_key_expansion.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------------
// key in   | in_valid / in_stall  | key_high, key_low
// round out| out_valid / out_stall| round_key_high, round_key_low, round_index, last_round
//
// One key gives eleven round keys, one per cycle while out_stall stays low; the pace
// is set by the single round unit, used once per round. The next key is taken in the
// cycle the last round key leaves. A high out_stall holds the current round key and
// the schedule.
// Reset returns the sequencer to idle with the round count and the schedule at zero.
module aes128_key_expansion (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,

    input  wire  logic                              in_valid,
    output logic                                    in_stall,
    input  wire  logic [aes_ke_pkg::HALF_W-1:0]     key_high,
    input  wire  logic [aes_ke_pkg::HALF_W-1:0]     key_low,

    output logic                                    out_valid,
    input  wire  logic                              out_stall,
    output logic [aes_ke_pkg::HALF_W-1:0]           round_key_high,
    output logic [aes_ke_pkg::HALF_W-1:0]           round_key_low,
    output logic [aes_ke_pkg::ROUND_W-1:0]          round_index,
    output logic                                    last_round
);
    import aes_ke_pkg::*;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    key_words_t          words_reg;
    key_words_t          words_next;
    logic [ROUND_W-1:0]  round_reg;
    logic [ROUND_W-1:0]  round_next;
    key_words_t          words_step;
    logic                in_take;
    logic                out_take;
    logic                at_last;

    // Shared round unit: fed from the held round key, builds the next one
    aes_ke_round u_round (
        .words     (words_reg),
        .round     (round_reg),
        .words_out (words_step)
    );

    assign at_last  = (round_reg == LAST_ROUND);
    assign out_take = out_valid && !out_stall;

    // Busy until the last round key of the current transaction leaves
    assign in_stall = (state_reg == ST_RUN) && !(at_last && !out_stall);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        words_next = words_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_RUN;
                    words_next = {key_high, key_low};
                    round_next = FIRST_ROUND;
                end
            end
            ST_RUN:
            begin
                if (out_take)
                begin
                    if (!at_last)
                    begin
                        // Advance one round
                        words_next = words_step;
                        round_next = round_reg + ROUND_W'(1);
                    end
                    else if (in_take)
                    begin
                        // Hand over straight to the next key
                        words_next = {key_high, key_low};
                        round_next = FIRST_ROUND;
                    end
                    else
                    begin
                        // Drop back to idle; round count stays at the last round
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= FIRST_ROUND;
            words_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            words_reg <= words_next;
        end
    end

    assign out_valid      = (state_reg == ST_RUN);
    assign round_key_high = {words_reg[0], words_reg[1]};
    assign round_key_low  = {words_reg[2], words_reg[3]};
    assign round_index    = round_reg;
    assign last_round     = at_last;

endmodule

`default_nettype wire

@@ rtl/aes_ke_round.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One key schedule step: four words in, the next four words out.
module aes_ke_round (
    input  wire aes_ke_pkg::key_words_t            words,
    input  wire logic [aes_ke_pkg::ROUND_W-1:0]    round,
    output aes_ke_pkg::key_words_t                 words_out
);
    import aes_ke_pkg::*;

    word_t rot;
    word_t sub;
    word_t t;

    always_comb
    begin
        rot = {words[3][23:0], words[3][31:24]};
        for (int b = 0; b < 4; b++)
        begin
            sub[8*b +: 8] = SBOX[rot[8*b +: 8]];
        end
        t = sub ^ rcon(round);

        // Chain each word onto the one before it
        words_out[0] = words[0] ^ t;
        words_out[1] = words[1] ^ words_out[0];
        words_out[2] = words[2] ^ words_out[1];
        words_out[3] = words[3] ^ words_out[2];
    end

endmodule

`default_nettype wire
